>>> rtl/core/mcdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcdd_pkg;

  // Register map of the configuration port
  localparam int unsigned NUM_PERIODS = 3;
  localparam int unsigned REG_IDX_W   = 2;
  localparam logic [REG_IDX_W-1:0] REG_CLOCK_PERIOD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_PERIOD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCAN_PERIOD  = 2'd2;

  localparam int unsigned PERIOD_W = 10;

  // Period register reset values
  localparam logic [PERIOD_W-1:0] CLOCK_PERIOD_RST = 10'd100;
  localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 10'd100;
  localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST  = 10'd25;

  // Time of day after reset
  localparam logic [4:0] HOUR_RST   = 5'd23;
  localparam logic [5:0] MINUTE_RST = 6'd59;
  localparam logic [5:0] SECOND_RST = 6'd55;

  localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
  localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
  localparam logic [4:0] HOURS_PER_DAY      = 5'd24;

  typedef logic [6:0] seg_t;
  typedef logic [3:0] enable_t;

  localparam seg_t    SEG_ALL_OFF = 7'h7F;
  localparam enable_t EN_ALL_OFF  = 4'hF;

  // Scan positions, left to right on the display
  localparam logic [1:0] POS_HOUR_TENS   = 2'd0;
  localparam logic [1:0] POS_HOUR_UNITS  = 2'd1;
  localparam logic [1:0] POS_MINUTE_TENS = 2'd2;
  localparam logic [1:0] POS_MINUTE_UNITS = 2'd3;

  // Active-low a..g pattern of one decimal digit
  function automatic seg_t seg_pattern(input logic [3:0] d);
    seg_t p;
    unique case (d)
      4'd0:    p = 7'h40;
      4'd1:    p = 7'h79;
      4'd2:    p = 7'h24;
      4'd3:    p = 7'h30;
      4'd4:    p = 7'h19;
      4'd5:    p = 7'h12;
      4'd6:    p = 7'h02;
      4'd7:    p = 7'h78;
      4'd8:    p = 7'h00;
      4'd9:    p = 7'h10;
      default: p = SEG_ALL_OFF;
    endcase
    return p;
  endfunction

  // Tens digit of a value below 64, by compare chain
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    t = '0;
    for (int i = 1; i < 7; i++) begin
      if (v >= 6'(10 * i)) t = 3'(i);
    end
    return t;
  endfunction

  // Units digit of a value below 64
  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] u;
    u = v - 6'(6'(tens_of(v)) * 6'd10);
    return u[3:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/multiplexed_clock_display_driver_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-digit HH:MM clock display driver for a common-anode multiplexed
// seven-segment display. Each accepted transaction on the tick channel is one
// base tick (tick high) or a no-op (tick low); every transaction yields exactly
// one result in the next cycle, holding the display drive, the blink level and
// the current time. A new tick is taken every cycle unless a held result stalls
// it: the counter, time-of-day and digit-decode update is a single level of
// shallow logic feeding the state and the result register, and the result
// register frees as it is read, so throughput is one transaction per cycle
// while results are taken. Clock, blink and scan periods default to 100, 100
// and 25 ticks; writing one reloads its counter; a zero period stops it.
module multiplexed_clock_display_driver_unit
  import mcdd_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 10
) (
  input  wire                       clk,
  input  wire                       rst,
  // tick channel
  input  wire                       tick_valid,
  output logic                      tick_ready,
  input  wire                       tick,
  // result channel
  output logic                      result_valid,
  input  wire                       result_ready,
  output logic [6:0]                segments,
  output logic [3:0]                digit_enables,
  output logic                      blink_level,
  output logic [4:0]                hours,
  output logic [5:0]                minutes,
  output logic [5:0]                seconds,
  // configuration channel
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [REG_IDX_W-1:0]      cfg_index,
  input  wire  [PERIOD_W-1:0]       cfg_data
);

  logic [PERIOD_W-1:0]      period_reg [NUM_PERIODS];
  logic [COUNTER_WIDTH-1:0] counter [NUM_PERIODS];
  logic [COUNTER_WIDTH-1:0] counter_next [NUM_PERIODS];
  logic [NUM_PERIODS-1:0]   fire;

  logic [4:0] hour_count, hour_next;
  logic [5:0] minute_count, minute_next;
  logic [5:0] second_count, second_next;
  logic [1:0] scan_position, scan_next;
  logic       blink_state, blink_next;
  seg_t       segment_drive, segment_next;
  enable_t    enable_drive, enable_next;

  logic [3:0] digit;
  logic       tick_accept;
  logic       cfg_write;

  assign tick_ready  = !result_valid || result_ready;
  assign tick_accept = tick_valid && tick_ready;
  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && (32'(cfg_index) < NUM_PERIODS);

  // Count down each period counter; fire and reload on reaching zero
  always_comb begin
    for (int k = 0; k < NUM_PERIODS; k++) begin
      counter_next[k] = counter[k];
      fire[k]         = 1'b0;
      if (tick && (counter[k] != '0)) begin
        counter_next[k] = counter[k] - COUNTER_WIDTH'(1);
        if (counter_next[k] == '0) begin
          counter_next[k] = COUNTER_WIDTH'(period_reg[k]);
          fire[k]         = 1'b1;
        end
      end
    end
  end

  // Advance the time of day with 60/60/24 rollover
  always_comb begin
    second_next = second_count;
    minute_next = minute_count;
    hour_next   = hour_count;
    if (fire[REG_CLOCK_PERIOD]) begin
      second_next = second_count + 6'd1;
      if (second_next >= SECONDS_PER_MINUTE) begin
        second_next = '0;
        minute_next = minute_count + 6'd1;
      end
      if (minute_next >= MINUTES_PER_HOUR) begin
        minute_next = '0;
        hour_next   = hour_count + 5'd1;
      end
      if (hour_next >= HOURS_PER_DAY) hour_next = '0;
    end
  end

  // Toggle the blink level
  assign blink_next = fire[REG_BLINK_PERIOD] ? ~blink_state : blink_state;

  // Step the scan and decode the selected digit of the updated time
  assign scan_next = fire[REG_SCAN_PERIOD] ? scan_position + 2'd1 : scan_position;

  always_comb begin
    unique case (scan_next)
      POS_HOUR_TENS:    digit = {1'b0, tens_of({1'b0, hour_next})};
      POS_HOUR_UNITS:   digit = units_of({1'b0, hour_next});
      POS_MINUTE_TENS:  digit = {1'b0, tens_of(minute_next)};
      POS_MINUTE_UNITS: digit = units_of(minute_next);
      default:          digit = '0;
    endcase
  end

  assign segment_next = fire[REG_SCAN_PERIOD] ? seg_pattern(digit) : segment_drive;
  assign enable_next  = fire[REG_SCAN_PERIOD] ? ~(enable_t'(1) << scan_next) : enable_drive;

  // Hold the period registers and counters; a write reloads its counter
  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg[REG_CLOCK_PERIOD] <= CLOCK_PERIOD_RST;
      period_reg[REG_BLINK_PERIOD] <= BLINK_PERIOD_RST;
      period_reg[REG_SCAN_PERIOD]  <= SCAN_PERIOD_RST;
      counter[REG_CLOCK_PERIOD]    <= COUNTER_WIDTH'(CLOCK_PERIOD_RST);
      counter[REG_BLINK_PERIOD]    <= COUNTER_WIDTH'(BLINK_PERIOD_RST);
      counter[REG_SCAN_PERIOD]     <= COUNTER_WIDTH'(SCAN_PERIOD_RST);
    end else begin
      for (int k = 0; k < NUM_PERIODS; k++) begin
        if (cfg_write && (cfg_index == REG_IDX_W'(k))) begin
          period_reg[k] <= cfg_data;
          counter[k]    <= COUNTER_WIDTH'(cfg_data);
        end else if (tick_accept) begin
          counter[k] <= counter_next[k];
        end
      end
    end
  end

  // Update the clock and display state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count    <= HOUR_RST;
      minute_count  <= MINUTE_RST;
      second_count  <= SECOND_RST;
      scan_position <= POS_HOUR_TENS;
      blink_state   <= 1'b1;
      segment_drive <= SEG_ALL_OFF;
      enable_drive  <= EN_ALL_OFF;
    end else if (tick_accept) begin
      hour_count    <= hour_next;
      minute_count  <= minute_next;
      second_count  <= second_next;
      scan_position <= scan_next;
      blink_state   <= blink_next;
      segment_drive <= segment_next;
      enable_drive  <= enable_next;
    end
  end

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tick_accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      segments      <= segment_next;
      digit_enables <= enable_next;
      blink_level   <= blink_next;
      hours         <= hour_next;
      minutes       <= minute_next;
      seconds       <= second_next;
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mcdd_pkg::*;

  localparam int unsigned CNT_W       = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  // Index past the register map; writes to it must be dropped
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [PERIOD_W-1:0]  PERIOD_ZERO = 10'd0;
  localparam logic [PERIOD_W-1:0]  PERIOD_ONE  = 10'd1;
  localparam logic [PERIOD_W-1:0]  PERIOD_MAX  = 10'd1023;

  typedef struct packed {
    seg_t       segments;
    enable_t    enables;
    logic       blink;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } display_t;

  logic clk = 1'b0;
  logic rst;

  logic                 tick_valid;
  logic                 tick_ready;
  logic                 tick;
  logic                 result_valid;
  logic                 result_ready;
  logic [6:0]           segments;
  logic [3:0]           digit_enables;
  logic                 blink_level;
  logic [4:0]           hours;
  logic [5:0]           minutes;
  logic [5:0]           seconds;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [PERIOD_W-1:0]  cfg_data;

  multiplexed_clock_display_driver_unit #(
    .COUNTER_WIDTH(CNT_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick         (tick),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .segments     (segments),
    .digit_enables(digit_enables),
    .blink_level  (blink_level),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the clock and display state
  logic [PERIOD_W-1:0] period_reg [NUM_PERIODS];
  logic [CNT_W-1:0]    period_cnt [NUM_PERIODS];
  logic [4:0]          hr_now;
  logic [5:0]          min_now;
  logic [5:0]          sec_now;
  logic [1:0]          scan_pos;
  logic                blink_now;
  seg_t                seg_now;
  enable_t             en_now;

  display_t    pending_displays [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off_cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;

  function automatic seg_t glyph(input logic [3:0] v);
    case (v)
      4'd0:    return 7'h40;
      4'd1:    return 7'h79;
      4'd2:    return 7'h24;
      4'd3:    return 7'h30;
      4'd4:    return 7'h19;
      4'd5:    return 7'h12;
      4'd6:    return 7'h02;
      4'd7:    return 7'h78;
      4'd8:    return 7'h00;
      4'd9:    return 7'h10;
      default: return SEG_ALL_OFF;
    endcase
  endfunction

  function automatic void reset_clock_state();
    period_reg[REG_CLOCK_PERIOD] = CLOCK_PERIOD_RST;
    period_reg[REG_BLINK_PERIOD] = BLINK_PERIOD_RST;
    period_reg[REG_SCAN_PERIOD]  = SCAN_PERIOD_RST;
    for (int k = 0; k < NUM_PERIODS; k++) period_cnt[k] = CNT_W'(period_reg[k]);
    hr_now    = HOUR_RST;
    min_now   = MINUTE_RST;
    sec_now   = SECOND_RST;
    scan_pos  = POS_HOUR_TENS;
    blink_now = 1'b1;
    seg_now   = SEG_ALL_OFF;
    en_now    = EN_ALL_OFF;
  endfunction

  // Load a period register; the matching counter restarts from it
  function automatic void load_period(input logic [REG_IDX_W-1:0] idx,
                                      input logic [PERIOD_W-1:0] data);
    if (int'(idx) < int'(NUM_PERIODS)) begin
      period_reg[idx] = data;
      period_cnt[idx] = CNT_W'(data);
    end
  endfunction

  // Count one counter down; report a fire and reload on reaching zero
  function automatic logic period_elapsed(input logic [REG_IDX_W-1:0] k);
    if (period_cnt[k] == '0) return 1'b0;
    period_cnt[k] = period_cnt[k] - CNT_W'(1);
    if (period_cnt[k] != '0) return 1'b0;
    period_cnt[k] = CNT_W'(period_reg[k]);
    return 1'b1;
  endfunction

  // Apply one tick transaction and return the display it leaves behind
  function automatic display_t next_display(input logic level);
    display_t   d;
    logic [3:0] digit;
    if (level) begin
      if (period_elapsed(REG_CLOCK_PERIOD)) begin
        if (sec_now == SECONDS_PER_MINUTE - 6'd1) begin
          sec_now = '0;
          if (min_now == MINUTES_PER_HOUR - 6'd1) begin
            min_now = '0;
            hr_now  = (hr_now == HOURS_PER_DAY - 5'd1) ? 5'd0 : hr_now + 5'd1;
          end else begin
            min_now = min_now + 6'd1;
          end
        end else begin
          sec_now = sec_now + 6'd1;
        end
      end
      if (period_elapsed(REG_BLINK_PERIOD)) blink_now = ~blink_now;
      if (period_elapsed(REG_SCAN_PERIOD)) begin
        scan_pos = scan_pos + 2'd1;
        case (scan_pos)
          POS_HOUR_TENS:   digit = 4'(hr_now / 5'd10);
          POS_HOUR_UNITS:  digit = 4'(hr_now % 5'd10);
          POS_MINUTE_TENS: digit = 4'(min_now / 6'd10);
          default:         digit = 4'(min_now % 6'd10);
        endcase
        seg_now = glyph(digit);
        en_now  = ~(enable_t'(1) << scan_pos);
      end
    end
    d.segments = seg_now;
    d.enables  = en_now;
    d.blink    = blink_now;
    d.hours    = hr_now;
    d.minutes  = min_now;
    d.seconds  = sec_now;
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return PERIOD_ZERO;
    if (r == 1) return PERIOD_MAX;
    if (r == 2) return PERIOD_W'($urandom_range(1023));
    return PERIOD_W'($urandom_range(12, 1));
  endfunction

  // Track every handshake: predict on tick, load on config, check on result
  always @(posedge clk) begin : monitor
    display_t want;
    if (!rst) begin
      if (tick_valid && tick_ready) pending_displays.push_back(next_display(tick));
      if (cfg_valid && cfg_ready) load_period(cfg_index, cfg_data);
      if (result_valid && result_ready) begin
        if (pending_displays.size() == 0) begin
          report_mismatch("result transaction with no tick pending");
        end else begin
          want = pending_displays.pop_front();
          if (segments !== want.segments)
            report_mismatch($sformatf("segments %h, want %h", segments, want.segments));
          if (digit_enables !== want.enables)
            report_mismatch($sformatf("digit_enables %h, want %h", digit_enables,
                                      want.enables));
          if (blink_level !== want.blink)
            report_mismatch($sformatf("blink_level %b, want %b", blink_level, want.blink));
          if (hours !== want.hours)
            report_mismatch($sformatf("hours %0d, want %0d", hours, want.hours));
          if (minutes !== want.minutes)
            report_mismatch($sformatf("minutes %0d, want %0d", minutes, want.minutes));
          if (seconds !== want.seconds)
            report_mismatch($sformatf("seconds %0d, want %0d", seconds, want.seconds));
        end
      end
    end
  end

  // Result side: random ready bursts and stalls, or a requested long hold-off
  initial begin : receiver
    int unsigned n;
    result_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!rx_stalls || $urandom_range(3) != 0) begin
        result_ready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end else begin
        result_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Offer one tick transaction; valid stays up so back-to-back items need no drop
  task automatic offer_tick(input logic level);
    int unsigned gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick       <= level;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every pending display has come back
  task automatic wait_idle();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [PERIOD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_periods(input logic [PERIOD_W-1:0] clock_p,
                                   input logic [PERIOD_W-1:0] blink_p,
                                   input logic [PERIOD_W-1:0] scan_p);
    write_register(REG_CLOCK_PERIOD, clock_p);
    write_register(REG_BLINK_PERIOD, blink_p);
    write_register(REG_SCAN_PERIOD, scan_p);
  endtask

  // Tick-low no-ops, then ticks while the display is still blank
  task automatic test_reset_state();
    repeat (2) offer_tick(1'b0);
    repeat (3) offer_tick(1'b1);
    wait_idle();
  endtask

  // Every counter fires each tick; the time rolls over midnight
  task automatic test_period_of_one();
    write_all_periods(PERIOD_ONE, PERIOD_ONE, PERIOD_ONE);
    repeat (8) offer_tick(1'b1);
    wait_idle();
  endtask

  // Stopped counters, a restart, and a write to an unmapped index
  task automatic test_zero_period();
    write_all_periods(PERIOD_ZERO, PERIOD_ZERO, PERIOD_ZERO);
    repeat (3) offer_tick(1'b1);
    wait_idle();
    write_register(REG_CLOCK_PERIOD, 10'd2);
    write_register(REG_UNUSED, PERIOD_MAX);
    write_register(REG_SCAN_PERIOD, PERIOD_ONE);
    repeat (3) offer_tick(1'b1);
    wait_idle();
  endtask

  task automatic test_max_period();
    write_all_periods(PERIOD_MAX, PERIOD_MAX, PERIOD_MAX);
    repeat (3) offer_tick(1'b1);
    wait_idle();
  endtask

  // Hold the result side off while ticks keep coming, so the input stalls
  task automatic test_back_pressure();
    write_all_periods(10'd3, 10'd2, PERIOD_ONE);
    hold_off_cycles = 120;
    while (hold_off_cycles != 0) @(posedge clk);
    tx_gaps = 1'b0;
    repeat (30) offer_tick(1'b1);
    wait_idle();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(3) != 0) write_register(REG_CLOCK_PERIOD, pick_period());
      if ($urandom_range(3) != 0) write_register(REG_BLINK_PERIOD, pick_period());
      if ($urandom_range(3) != 0) write_register(REG_SCAN_PERIOD, pick_period());
      if ($urandom_range(3) == 0) write_register(REG_UNUSED, PERIOD_W'($urandom()));
      // first phase runs with no idling on either side
      tx_gaps   = (phase != 0) && ($urandom_range(3) != 0);
      rx_stalls = (phase != 0) && ($urandom_range(3) != 0);
      repeat (ITEMS_PER_PHASE) offer_tick($urandom_range(9) != 0);
      wait_idle();
    end
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    tick_valid <= 1'b0;
    tick       <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    reset_clock_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_period_of_one();
    test_zero_period();
    test_max_period();
    test_back_pressure();
    test_random_traffic();

    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
